### rtl/cgbm_pkg.sv
// Shared types, widths and constants for the correlated GBM path step block.
// Used by the multiplier, the top level and the checker; depends on nothing.
package cgbm_pkg;

    localparam int MAX_ASSETS_DEF = 8;

    localparam int PRICE_W = 40;
    localparam int VAL_W   = 16;
    localparam int DT_W    = 24;
    localparam int CNT_W   = 4;
    localparam int STEP_W  = 16;

    // shared multiplier: signed A by signed B, full product
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [PRICE_W-1:0] PRICE_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic signed [43:0] EXP_CLIP   = 44'sd68719476736;
    localparam logic [37:0]        LN2_Q32    = 38'd2977044472;
    // 24 * ln2 in Q.32, lifts the clipped exponent above zero
    localparam logic [37:0]        Q_OFS      = 38'd71449067328;
    localparam logic signed [6:0]  Q_BIAS     = 7'sd24;
    localparam logic [31:0]        ONE_Q30    = 32'h4000_0000;
    localparam logic [3:0]         SERIES_TERMS = 4'd12;

    typedef enum logic [1:0] {
        OP_LOAD_ASSET  = 2'd0,
        OP_LOAD_FACTOR = 2'd1,
        OP_START       = 2'd2,
        OP_SAMPLE      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_RATE       = 3'd0,
        REG_DT         = 3'd1,
        REG_ROOT_DT    = 3'd2,
        REG_DRIFT_MODE = 3'd3,
        REG_ASSET_CNT  = 3'd4
    } reg_idx_t;

    // floor(2^32 / t) for the series divisors
    function automatic logic [32:0] recip_q32(input logic [3:0] t);
        logic [32:0] r;
        case (t)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/cgbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the correlation factor table; no package dependency.
module cgbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata_reg
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule

### rtl/cgbm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on cgbm_pkg for operand widths.
module cgbm_mul (
    input  logic                                  aclk,
    input  logic signed [cgbm_pkg::MUL_A_W-1:0]   mul_a,
    input  logic signed [cgbm_pkg::MUL_B_W-1:0]   mul_b,
    output logic signed [cgbm_pkg::MUL_P_W-1:0]   prod_reg
);
    import cgbm_pkg::*;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end
endmodule

### rtl/correlated_gbm_path_step.sv
// Top level: configuration port, asset tables, sequencer driving the shared multiplier.
// Depends on cgbm_pkg, cgbm_ram and cgbm_mul.
//
//   channel   direction  handshake           carries
//   s_*       in         s_valid / s_ready   op, asset, factor column, three values
//   m_*       out        m_valid / m_ready   asset, step, price, saturated, last
//   apb       in         psel/penable        five configuration registers
//
// Load, factor and start words are taken in the idle state and leave the sequencer
// idle. A sample word for asset k runs the shock dot product over k+1 factor terms,
// then drift, diffusion and clipping, the range reduction, the twelve-term series and
// the price scaling, all through the one multiplier, and then, once the result register
// is free, loads the result register.
// Reset is synchronous, active low; it clears prices, step count and registers.
// A held result stalls the sequencer only at its final step.
module correlated_gbm_path_step #(
    parameter int MAX_ASSETS = cgbm_pkg::MAX_ASSETS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [2:0]                        s_asset_index,
    input  logic [2:0]                        s_factor_column,
    input  logic [cgbm_pkg::PRICE_W-1:0]      s_value_a,
    input  logic [cgbm_pkg::VAL_W-1:0]        s_value_b,
    input  logic signed [cgbm_pkg::VAL_W-1:0] s_value_c,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_out_asset,
    output logic [cgbm_pkg::STEP_W-1:0]       m_out_step,
    output logic [cgbm_pkg::PRICE_W-1:0]      m_price,
    output logic                              m_saturated,
    output logic                              m_last_of_step,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import cgbm_pkg::*;

    localparam int IDX_W = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
    localparam int FA_W  = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS * MAX_ASSETS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SH_RD, ST_SH_MUL, ST_SH_ACC, ST_SIG_MUL, ST_SIG_ACC,
        ST_DT_MUL, ST_DT_ACC, ST_SK_MUL, ST_SK_ACC, ST_RD_MUL, ST_RD_ACC,
        ST_CLIP, ST_DIV, ST_SER_MUL, ST_SER_RCP, ST_SER_DIV,
        ST_SC_HI, ST_SC_LO, ST_SC_FIN, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [VAL_W-1:0] rate_reg;
    logic [DT_W-1:0]         dt_reg;
    logic [DT_W-1:0]         rdt_reg;
    logic                    drift_mode_reg;
    logic [CNT_W-1:0]        asset_cnt_reg;

    // asset tables
    logic [PRICE_W-1:0] spot_reg   [MAX_ASSETS];
    logic [VAL_W-1:0]   sigma_reg  [MAX_ASSETS];
    logic [VAL_W-1:0]   trend_reg  [MAX_ASSETS];
    logic [VAL_W-1:0]   sample_reg [MAX_ASSETS];
    logic [PRICE_W-1:0] price_reg  [MAX_ASSETS];
    logic [STEP_W-1:0]  step_cnt_reg;

    // working registers of one sample
    logic [2:0]           k_reg;
    logic [IDX_W-1:0]     j_reg;
    logic signed [35:0]   shock_reg;
    logic signed [33:0]   a_reg;
    logic signed [35:0]   t1_reg;
    logic signed [43:0]   x_reg;
    logic [37:0]          rem_reg;
    logic [5:0]           qq_reg;
    logic [2:0]           bit_reg;
    logic [31:0]          acc_reg;
    logic [30:0]          v_reg;
    logic [3:0]           term_reg;
    logic [50:0]          thi_reg;
    logic [PRICE_W-1:0]   res_reg;
    logic                 sat_reg;

    // result register
    logic                 m_valid_reg;
    logic [2:0]           m_asset_reg;
    logic [STEP_W-1:0]    m_step_reg;
    logic [PRICE_W-1:0]   m_price_reg;
    logic                 m_sat_reg;
    logic                 m_last_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_RATE:       prdata = 32'(unsigned'(rate_reg));
            REG_DT:         prdata = 32'(dt_reg);
            REG_ROOT_DT:    prdata = 32'(rdt_reg);
            REG_DRIFT_MODE: prdata = 32'(drift_mode_reg);
            REG_ASSET_CNT:  prdata = 32'(asset_cnt_reg);
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg       <= '0;
            dt_reg         <= '0;
            rdt_reg        <= '0;
            drift_mode_reg <= 1'b0;
            asset_cnt_reg  <= CNT_W'(1);
        end else if (cfg_we) begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_RATE:       rate_reg       <= pwdata[VAL_W-1:0];
                REG_DT:         dt_reg         <= pwdata[DT_W-1:0];
                REG_ROOT_DT:    rdt_reg        <= pwdata[DT_W-1:0];
                REG_DRIFT_MODE: drift_mode_reg <= pwdata[0];
                REG_ASSET_CNT:  asset_cnt_reg  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic             s_fire;
    logic             k_ok;
    logic             col_ok;
    logic [IDX_W-1:0] k_in;
    logic [IDX_W-1:0] k_idx;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign k_ok    = 32'(s_asset_index) < MAX_ASSETS;
    assign col_ok  = 32'(s_factor_column) < MAX_ASSETS;
    assign k_in    = IDX_W'(s_asset_index);
    assign k_idx   = IDX_W'(k_reg);

    // ------------------------------------------------------------------
    // Factor table
    // ------------------------------------------------------------------
    logic             fac_we;
    logic [FA_W-1:0]  fac_waddr;
    logic [FA_W-1:0]  fac_raddr;
    logic [VAL_W-1:0] fac_rdata;

    assign fac_we    = s_fire && (op_t'(s_op) == OP_LOAD_FACTOR) && k_ok && col_ok;
    assign fac_waddr = FA_W'(32'(s_asset_index) * MAX_ASSETS + 32'(s_factor_column));
    assign fac_raddr = FA_W'(32'(k_reg) * MAX_ASSETS + 32'(j_reg));

    cgbm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ASSETS * MAX_ASSETS)
    ) u_factor_ram (
        .aclk      (aclk),
        .we        (fac_we),
        .waddr     (fac_waddr),
        .wdata     (s_value_a[VAL_W-1:0]),
        .raddr     (fac_raddr),
        .rdata_reg (fac_rdata)
    );

    // ------------------------------------------------------------------
    // Shared multiplier and its operand select
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [30:0]               v_now;

    assign v_now = mul_p[60:30];

    always_comb begin
        unique case (state_reg)
            ST_SH_MUL: begin
                mul_a = MUL_A_W'(signed'(fac_rdata));
                mul_b = MUL_B_W'(signed'(sample_reg[j_reg]));
            end
            ST_SIG_MUL: begin
                mul_a = MUL_A_W'(sigma_reg[k_idx]);
                mul_b = MUL_B_W'(sigma_reg[k_idx]);
            end
            ST_DT_MUL: begin
                mul_a = MUL_A_W'(a_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            ST_SK_MUL: begin
                mul_a = shock_reg;
                mul_b = MUL_B_W'(sigma_reg[k_idx]);
            end
            ST_RD_MUL: begin
                mul_a = t1_reg;
                mul_b = MUL_B_W'(rdt_reg);
            end
            ST_SER_MUL: begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'(rem_reg[31:2]);
            end
            ST_SER_RCP: begin
                mul_a = MUL_A_W'(v_now);
                mul_b = MUL_B_W'(recip_q32(term_reg));
            end
            ST_SC_HI: begin
                mul_a = MUL_A_W'(price_reg[k_idx][39:20]);
                mul_b = MUL_B_W'(acc_reg);
            end
            ST_SC_LO: begin
                mul_a = MUL_A_W'(price_reg[k_idx][19:0]);
                mul_b = MUL_B_W'(acc_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cgbm_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (mul_p)
    );

    // ------------------------------------------------------------------
    // Per-step arithmetic
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] drift;
    logic signed [43:0]      x_clip;
    logic                    clip_hit;
    logic [37:0]             div_cmp;
    logic [30:0]             est;
    logic [34:0]             est_t;
    logic [34:0]             rem_v;
    logic [31:0]             quo;
    logic [52:0]             low_sum;
    logic [41:0]             r_scaled;
    logic signed [6:0]       q_exp;
    logic [4:0]              neg_q;
    logic [65:0]             shifted;
    logic                    over;

    assign drift = drift_mode_reg ? signed'(trend_reg[k_idx]) : rate_reg;

    always_comb begin
        clip_hit = 1'b1;
        if (x_reg > EXP_CLIP) begin
            x_clip = EXP_CLIP;
        end else if (x_reg < -EXP_CLIP) begin
            x_clip = -EXP_CLIP;
        end else begin
            x_clip   = x_reg;
            clip_hit = 1'b0;
        end
    end

    assign div_cmp = LN2_Q32 << bit_reg;

    // quotient estimate from the reciprocal is low by at most one
    assign est   = mul_p[62:32];
    assign est_t = 35'(est) * 35'(term_reg);
    assign rem_v = 35'(v_reg) - est_t;
    assign quo   = (rem_v >= 35'(term_reg)) ? 32'(est) + 32'd1 : 32'(est);

    // floor(price * m / 2^30) from the high and low half products
    assign low_sum  = {23'd0, thi_reg[9:0], 20'd0} + 53'(mul_p[51:0]);
    assign r_scaled = 42'(thi_reg[50:10]) + 42'(low_sum[52:30]);
    assign q_exp    = signed'({1'b0, qq_reg}) - Q_BIAS;
    assign neg_q    = 5'(-q_exp);
    assign shifted  = (q_exp >= 0) ? (66'(r_scaled) << q_exp[4:0])
                                   : (66'(r_scaled) >> neg_q);
    assign over     = shifted > 66'(PRICE_MAX);

    // ------------------------------------------------------------------
    // Table writes (no reset: undefined until loaded)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire && k_ok) begin
            if (op_t'(s_op) == OP_LOAD_ASSET) begin
                spot_reg[k_in]  <= s_value_a;
                sigma_reg[k_in] <= s_value_b;
                trend_reg[k_in] <= s_value_c;
            end
            if (op_t'(s_op) == OP_SAMPLE) begin
                sample_reg[k_in] <= s_value_a[VAL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, prices and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            step_cnt_reg <= '0;
            for (int i = 0; i < MAX_ASSETS; i++) begin
                price_reg[i] <= '0;
            end
        end else begin
            // drop the accepted word; the final step reloads it itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (op_t'(s_op))
                            OP_START: begin
                                for (int i = 0; i < MAX_ASSETS; i++) begin
                                    price_reg[i] <= spot_reg[i];
                                end
                                step_cnt_reg <= '0;
                            end
                            OP_SAMPLE: begin
                                if (k_ok) begin
                                    if (s_asset_index == 3'd0) begin
                                        step_cnt_reg <= step_cnt_reg + STEP_W'(1);
                                    end
                                    k_reg     <= s_asset_index;
                                    j_reg     <= '0;
                                    shock_reg <= '0;
                                    sat_reg   <= 1'b0;
                                    state_reg <= ST_SH_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SH_RD:  state_reg <= ST_SH_MUL;
                ST_SH_MUL: state_reg <= ST_SH_ACC;
                ST_SH_ACC: begin
                    shock_reg <= shock_reg + 36'(mul_p);
                    if (32'(j_reg) == 32'(k_reg)) begin
                        state_reg <= ST_SIG_MUL;
                    end else begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= ST_SH_RD;
                    end
                end
                ST_SIG_MUL: state_reg <= ST_SIG_ACC;
                ST_SIG_ACC: begin
                    a_reg <= 34'(signed'({drift, 16'h0000}))
                           - signed'({2'b00, mul_p[32:1]});
                    state_reg <= ST_DT_MUL;
                end
                ST_DT_MUL: state_reg <= ST_DT_ACC;
                ST_DT_ACC: begin
                    x_reg     <= 44'(mul_p >>> 24);
                    state_reg <= ST_SK_MUL;
                end
                ST_SK_MUL: state_reg <= ST_SK_ACC;
                ST_SK_ACC: begin
                    t1_reg    <= 36'(mul_p >>> 16);
                    state_reg <= ST_RD_MUL;
                end
                ST_RD_MUL: state_reg <= ST_RD_ACC;
                ST_RD_ACC: begin
                    x_reg     <= x_reg + 44'(mul_p >>> 18);
                    state_reg <= ST_CLIP;
                end
                ST_CLIP: begin
                    // clip and bias so that the reduction works on a positive value
                    if (clip_hit) begin
                        sat_reg <= 1'b1;
                    end
                    rem_reg   <= 38'(x_clip + signed'({6'd0, Q_OFS}));
                    qq_reg    <= '0;
                    bit_reg   <= 3'd5;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (rem_reg >= div_cmp) begin
                        rem_reg         <= rem_reg - div_cmp;
                        qq_reg[bit_reg] <= 1'b1;
                    end
                    if (bit_reg == 3'd0) begin
                        acc_reg   <= ONE_Q30;
                        term_reg  <= SERIES_TERMS;
                        state_reg <= ST_SER_MUL;
                    end else begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                ST_SER_MUL: state_reg <= ST_SER_RCP;
                ST_SER_RCP: begin
                    v_reg     <= v_now;
                    state_reg <= ST_SER_DIV;
                end
                ST_SER_DIV: begin
                    acc_reg  <= ONE_Q30 + quo;
                    term_reg <= term_reg - 4'd1;
                    if (term_reg == 4'd1) begin
                        state_reg <= ST_SC_HI;
                    end else begin
                        state_reg <= ST_SER_MUL;
                    end
                end
                ST_SC_HI: state_reg <= ST_SC_LO;
                ST_SC_LO: begin
                    thi_reg   <= mul_p[50:0];
                    state_reg <= ST_SC_FIN;
                end
                ST_SC_FIN: begin
                    if (over) begin
                        res_reg <= PRICE_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        res_reg <= shifted[PRICE_W-1:0];
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_ready) begin
                        price_reg[k_idx] <= res_reg;
                        m_valid_reg      <= 1'b1;
                        m_asset_reg      <= k_reg;
                        m_step_reg       <= step_cnt_reg;
                        m_price_reg      <= res_reg;
                        m_sat_reg        <= sat_reg;
                        m_last_reg       <= ({1'b0, k_reg} + 4'd1) == asset_cnt_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_asset    = m_asset_reg;
    assign m_out_step     = m_step_reg;
    assign m_price        = m_price_reg;
    assign m_saturated    = m_sat_reg;
    assign m_last_of_step = m_last_reg;

endmodule

### rtl/cgbm_chk.sv
// Port-level checker for correlated_gbm_path_step, bound to the top level.
// Depends on cgbm_pkg for the operation codes.
module cgbm_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [1:0]                        s_op,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [cgbm_pkg::PRICE_W-1:0]      m_price,
    input logic                              pready
);
    import cgbm_pkg::*;

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_price))
        else $error("stalled result word changed");

    a_short_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op != OP_SAMPLE) |=> s_ready)
        else $error("load or start word did not complete in one cycle");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op != OP_SAMPLE) |=> !$rose(m_valid))
        else $error("result word from a word that gives none");

endmodule

bind correlated_gbm_path_step cgbm_chk u_cgbm_chk (.*);
